>>> hdl/ascii_reply_frame_parser_defines.svh
// Assertion macros shared by the reply parser RTL.
`ifndef ASCII_REPLY_FRAME_PARSER_DEFINES_SVH
`define ASCII_REPLY_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ARFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ARFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/arfp_pkg.sv
// Shared types and constants for the ASCII reply frame parser.
`default_nettype none
package arfp_pkg;

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_ARM     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_ACK     = 3'd0,
    ST_NAK     = 3'd1,
    ST_FORMAT  = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_UNEXP   = 3'd4,
    ST_IDLE_TO = 3'd5
  } status_t;

  typedef enum logic [6:0] {
    PH_SEEK    = 7'b0000001,
    PH_HDR     = 7'b0000010,
    PH_KEY     = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_DIGITS  = 7'b0010000,
    PH_HEX1    = 7'b0100000,
    PH_HEX2    = 7'b1000000
  } phase_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UC    = 8'h43;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UK    = 8'h4B;
  localparam logic [7:0] CH_UN    = 8'h4E;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;

  localparam int unsigned HDR_LEN = 5;
  localparam int unsigned KEY_LEN = 3;

  // Index of the final character of the header and of the keyword.
  localparam logic [2:0] HDR_LAST = 3'(HDR_LEN - 1);
  localparam logic [2:0] KEY_LAST = 3'(KEY_LEN - 1);

  localparam logic [9:0] NAK_CODE_MAX = 10'd999;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    status_t    status;
    logic [9:0] nak_code;
    logic       checksum_ok;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/arfp_parse_core.sv
// Frame state machine: parse state registers and the per-byte next-state logic.
`default_nettype none
module arfp_parse_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [1:0]       op,
  input  wire logic [7:0]       rx_byte,
  output logic                  res_valid,
  output arfp_pkg::result_t     res
);

  logic                armed_r, armed_nxt;
  arfp_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [3:0]          hi_r, hi_nxt;
  logic [9:0]          code_r, code_nxt;
  logic                nak_r, nak_nxt;

  logic [4:0]          hex;
  logic [7:0]          sum_add;
  logic [7:0]          hdr_exp;
  logic                nak_eff;
  logic [7:0]          key_exp;
  logic [13:0]         code_prod;
  logic                is_digit;

  logic                emit;
  logic                fin;
  arfp_pkg::status_t   fin_st;
  logic [9:0]          fin_code;
  logic                fin_ok;
  logic                emit_pay;

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= arfp_pkg::CH_ZERO && c <= arfp_pkg::CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= arfp_pkg::CH_LA && c <= arfp_pkg::CH_LF) ||
                 (c >= arfp_pkg::CH_UA && c <= arfp_pkg::CH_UF)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] key_char(input logic nak, input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = nak ? arfp_pkg::CH_UN : arfp_pkg::CH_UA;
      2'd1:    r = nak ? arfp_pkg::CH_UA : arfp_pkg::CH_UC;
      default: r = arfp_pkg::CH_UK;
    endcase
    return r;
  endfunction

  assign hex       = hex_decode(rx_byte);
  assign sum_add   = sum_r + rx_byte;
  assign hdr_exp   = (idx_r < 3'd2) ? arfp_pkg::CH_AT : arfp_pkg::CH_ZERO;
  assign nak_eff   = (idx_r == 3'd0) ? (rx_byte != arfp_pkg::CH_UA) : nak_r;
  assign key_exp   = key_char(nak_eff, idx_r[1:0]);
  assign is_digit  = (rx_byte >= arfp_pkg::CH_ZERO) && (rx_byte <= arfp_pkg::CH_NINE);
  assign code_prod = ({4'd0, code_r} << 3) + ({4'd0, code_r} << 1) + {10'd0, rx_byte[3:0]};

  always_comb begin
    armed_nxt = armed_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    code_nxt  = code_r;
    nak_nxt   = nak_r;
    emit      = 1'b0;
    fin       = 1'b0;
    fin_st    = arfp_pkg::ST_FORMAT;
    fin_code  = '0;
    fin_ok    = 1'b0;
    emit_pay  = 1'b0;

    if (fire) begin
      case (op)
        arfp_pkg::OP_BYTE: begin
          if (!armed_r) begin
            emit   = 1'b1;
            fin_st = arfp_pkg::ST_UNEXP;
          end else begin
            unique case (phase_r)
              arfp_pkg::PH_SEEK: begin
                if (rx_byte == arfp_pkg::CH_AT) begin
                  sum_nxt   = rx_byte;
                  idx_nxt   = '0;
                  phase_nxt = arfp_pkg::PH_HDR;
                end
              end
              arfp_pkg::PH_HDR: begin
                if (idx_r > arfp_pkg::HDR_LAST || rx_byte != hdr_exp) begin
                  fin = 1'b1;
                end else begin
                  sum_nxt = sum_add;
                  if (idx_r == arfp_pkg::HDR_LAST) begin
                    idx_nxt   = '0;
                    phase_nxt = arfp_pkg::PH_KEY;
                  end else begin
                    idx_nxt = idx_r + 3'd1;
                  end
                end
              end
              arfp_pkg::PH_KEY: begin
                if (idx_r > arfp_pkg::KEY_LAST || rx_byte != key_exp) begin
                  fin = 1'b1;
                end else begin
                  nak_nxt = nak_eff;
                  sum_nxt = sum_add;
                  if (idx_r == arfp_pkg::KEY_LAST) begin
                    idx_nxt   = '0;
                    phase_nxt = nak_eff ? arfp_pkg::PH_DIGITS : arfp_pkg::PH_PAYLOAD;
                  end else begin
                    idx_nxt = idx_r + 3'd1;
                  end
                end
              end
              arfp_pkg::PH_PAYLOAD: begin
                sum_nxt = sum_add;
                if (rx_byte == arfp_pkg::CH_SEMI) begin
                  phase_nxt = arfp_pkg::PH_HEX1;
                end else begin
                  emit_pay = 1'b1;
                end
              end
              arfp_pkg::PH_DIGITS: begin
                if (is_digit) begin
                  code_nxt = (code_prod > {4'd0, arfp_pkg::NAK_CODE_MAX}) ?
                             arfp_pkg::NAK_CODE_MAX : code_prod[9:0];
                  idx_nxt  = 3'd1;
                  sum_nxt  = sum_add;
                end else if (rx_byte == arfp_pkg::CH_SEMI && idx_r != 3'd0) begin
                  sum_nxt   = sum_add;
                  idx_nxt   = '0;
                  phase_nxt = arfp_pkg::PH_HEX1;
                end else begin
                  fin = 1'b1;
                end
              end
              arfp_pkg::PH_HEX1: begin
                if (!hex[4]) begin
                  fin = 1'b1;
                end else begin
                  hi_nxt    = hex[3:0];
                  phase_nxt = arfp_pkg::PH_HEX2;
                end
              end
              arfp_pkg::PH_HEX2: begin
                fin = 1'b1;
                if (hex[4]) begin
                  fin_ok = ({hi_r, hex[3:0]} == sum_r);
                  if (nak_r) begin
                    fin_st   = arfp_pkg::ST_NAK;
                    fin_code = code_r;
                  end else begin
                    fin_st = arfp_pkg::ST_ACK;
                  end
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
        arfp_pkg::OP_ARM: begin
          armed_nxt = 1'b1;
          phase_nxt = arfp_pkg::PH_SEEK;
          idx_nxt   = '0;
          sum_nxt   = '0;
          hi_nxt    = '0;
          code_nxt  = '0;
          nak_nxt   = 1'b0;
        end
        arfp_pkg::OP_TIMEOUT: begin
          fin    = 1'b1;
          fin_st = armed_r ? arfp_pkg::ST_TIMEOUT : arfp_pkg::ST_IDLE_TO;
        end
        default: ;
      endcase
    end

    // Close the frame: disarm and clear the parse state.
    if (fin) begin
      emit      = 1'b1;
      armed_nxt = 1'b0;
      phase_nxt = arfp_pkg::PH_SEEK;
      idx_nxt   = '0;
      sum_nxt   = '0;
      hi_nxt    = '0;
      code_nxt  = '0;
      nak_nxt   = 1'b0;
    end
  end

  always_comb begin
    res_valid = emit || emit_pay;
    res       = '0;
    if (emit) begin
      res.kind        = arfp_pkg::KIND_STATUS;
      res.status      = fin_st;
      res.nak_code    = fin_code;
      res.checksum_ok = fin_ok;
      res.last        = 1'b1;
    end else begin
      res.kind         = arfp_pkg::KIND_PAYLOAD;
      res.payload_byte = emit_pay ? rx_byte : 8'd0;
      res.status       = arfp_pkg::ST_ACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      phase_r <= arfp_pkg::PH_SEEK;
      idx_r   <= '0;
      sum_r   <= '0;
      hi_r    <= '0;
      code_r  <= '0;
      nak_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      hi_r    <= hi_nxt;
      code_r  <= code_nxt;
      nak_r   <= nak_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/arfp_out_reg.sv
// Result register holding one transaction until the receiver takes it.
`default_nettype none
module arfp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire arfp_pkg::result_t load_data,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output arfp_pkg::result_t     out_data
);

  logic              valid_r, valid_nxt;
  arfp_pkg::result_t data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset; load only when the slot is free or draining.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> hdl/ascii_reply_frame_parser.sv
// Parses ACK/NAK ASCII reply frames one byte a transaction: an item
// (received byte, arm request or timeout) can be accepted every clock cycle
// while in_stall is low. An accepted item waits in the input register until
// the result slot is empty or draining, then passes the frame state machine
// and its result, if any, is written to the result register and offered on
// the output from there. One item can be held in each register, so the input
// side keeps accepting while a result waits; in_stall rises only when both the
// input register and the result register are full and out_stall is high.
// Payload bytes come out as they arrive; each frame ends with one status
// transaction with last set. No clearing pass runs after reset.
`default_nettype none
`include "ascii_reply_frame_parser_defines.svh"
module ascii_reply_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_kind,
  output logic [7:0]      out_payload_byte,
  output logic [2:0]      out_status,
  output logic [9:0]      out_nak_code,
  output logic            out_checksum_ok,
  output logic            out_last
);

  logic              in_valid_r, in_valid_nxt;
  logic [1:0]        in_op_r;
  logic [7:0]        in_byte_r;
  logic              in_accept;
  logic              advance;
  logic              res_valid;
  logic              pay_res;
  arfp_pkg::result_t res;
  arfp_pkg::result_t out_data;

  // Advance the held item when the result slot is empty or being drained.
  assign advance   = in_valid_r && (!out_valid || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_op_r   <= in_op;
      in_byte_r <= in_rx_byte;
    end
  end

  arfp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .op        (in_op_r),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  arfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_payload_byte = out_data.payload_byte;
  assign out_status       = out_data.status;
  assign out_nak_code     = out_data.nak_code;
  assign out_checksum_ok  = out_data.checksum_ok;
  assign out_last         = out_data.last;

  assign pay_res = res_valid && (res.kind == arfp_pkg::KIND_PAYLOAD);

  `ARFP_ASSERT_NOW(a_res_only_on_advance, res_valid, advance, "result without advance")
  `ARFP_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "early stall")
  `ARFP_ASSERT_NEXT(a_result_lands, res_valid, out_valid, "result not registered")
  `ARFP_ASSERT_NOW(a_payload_op, pay_res, in_op_r == arfp_pkg::OP_BYTE, "bad payload op")

endmodule
`default_nettype wire

>>> tb/ascii_reply_frame_parser_checker.sv
// Reply parser checker: predicts every result transaction and compares it with the block's output.
module ascii_reply_frame_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_kind,
  input  logic [7:0]  out_payload_byte,
  input  logic [2:0]  out_status,
  input  logic [9:0]  out_nak_code,
  input  logic        out_checksum_ok,
  input  logic        out_last,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  arfp_pkg::result_t pending_results[$];
  int unsigned       errs = 0;

  // Parser state as the block should hold it
  bit                armed     = 1'b0;
  arfp_pkg::phase_t  ph        = arfp_pkg::PH_SEEK;
  logic [2:0]        idx       = '0;
  logic [7:0]        sum_acc   = '0;
  logic [7:0]        sum_rx    = '0;
  logic [9:0]        code_acc  = '0;
  bit                nak_path  = 1'b0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void clear_frame();
    ph       = arfp_pkg::PH_SEEK;
    idx      = '0;
    sum_acc  = '0;
    sum_rx   = '0;
    code_acc = '0;
    nak_path = 1'b0;
  endfunction

  function automatic arfp_pkg::result_t status_word(arfp_pkg::status_t st, logic [9:0] code,
                                                    logic ok);
    arfp_pkg::result_t r;
    r.kind         = arfp_pkg::KIND_STATUS;
    r.payload_byte = '0;
    r.status       = st;
    r.nak_code     = code;
    r.checksum_ok  = ok;
    r.last         = 1'b1;
    return r;
  endfunction

  function automatic arfp_pkg::result_t end_frame(arfp_pkg::status_t st, logic [9:0] code,
                                                  logic ok);
    armed = 1'b0;
    clear_frame();
    return status_word(st, code, ok);
  endfunction

  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] v);
    v = '0;
    if (b >= arfp_pkg::CH_ZERO && b <= arfp_pkg::CH_NINE) v = 4'(b - arfp_pkg::CH_ZERO);
    else if (b >= arfp_pkg::CH_LA && b <= arfp_pkg::CH_LF) v = 4'(b - arfp_pkg::CH_LA + 8'd10);
    else if (b >= arfp_pkg::CH_UA && b <= arfp_pkg::CH_UF) v = 4'(b - arfp_pkg::CH_UA + 8'd10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] keyword_char(bit nak, logic [2:0] i);
    case (i)
      3'd0:    return nak ? arfp_pkg::CH_UN : arfp_pkg::CH_UA;
      3'd1:    return nak ? arfp_pkg::CH_UA : arfp_pkg::CH_UC;
      default: return arfp_pkg::CH_UK;
    endcase
  endfunction

  // Advance the parser by one input transaction; return 1 when it yields a result
  function automatic bit decode_reply_step(input logic [1:0] op, input logic [7:0] b,
                                           output arfp_pkg::result_t r);
    logic [3:0]  nib;
    int unsigned code_next;
    r = '0;
    case (op)
      arfp_pkg::OP_BYTE: begin
        if (!armed) begin
          r = status_word(arfp_pkg::ST_UNEXP, '0, 1'b0);
          return 1'b1;
        end
        case (ph)
          arfp_pkg::PH_SEEK: begin
            if (b == arfp_pkg::CH_AT) begin
              sum_acc = b;
              idx     = '0;
              ph      = arfp_pkg::PH_HDR;
            end
            return 1'b0;
          end
          arfp_pkg::PH_HDR: begin
            if (b != ((idx < 2) ? arfp_pkg::CH_AT : arfp_pkg::CH_ZERO)) begin
              r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
              return 1'b1;
            end
            sum_acc = sum_acc + b;
            idx     = idx + 3'd1;
            if (idx == arfp_pkg::HDR_LEN) begin
              idx = '0;
              ph  = arfp_pkg::PH_KEY;
            end
            return 1'b0;
          end
          arfp_pkg::PH_KEY: begin
            // Anything but 'A' first commits to the NAK spelling
            if (idx == 0) nak_path = (b != arfp_pkg::CH_UA);
            if (b != keyword_char(nak_path, idx)) begin
              r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
              return 1'b1;
            end
            sum_acc = sum_acc + b;
            idx     = idx + 3'd1;
            if (idx == arfp_pkg::KEY_LEN) begin
              idx = '0;
              ph  = nak_path ? arfp_pkg::PH_DIGITS : arfp_pkg::PH_PAYLOAD;
            end
            return 1'b0;
          end
          arfp_pkg::PH_PAYLOAD: begin
            sum_acc = sum_acc + b;
            if (b == arfp_pkg::CH_SEMI) begin
              ph = arfp_pkg::PH_HEX1;
              return 1'b0;
            end
            r.kind         = arfp_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.status       = arfp_pkg::ST_ACK;
            return 1'b1;
          end
          arfp_pkg::PH_DIGITS: begin
            if (b >= arfp_pkg::CH_ZERO && b <= arfp_pkg::CH_NINE) begin
              code_next = code_acc * 10 + (b - arfp_pkg::CH_ZERO);
              code_acc  = (code_next > arfp_pkg::NAK_CODE_MAX) ?
                          arfp_pkg::NAK_CODE_MAX : code_next[9:0];
              idx       = 3'd1;
              sum_acc   = sum_acc + b;
              return 1'b0;
            end
            // A semicolon counts only once a digit has been seen
            if (b == arfp_pkg::CH_SEMI && idx != 0) begin
              sum_acc = sum_acc + b;
              idx     = '0;
              ph      = arfp_pkg::PH_HEX1;
              return 1'b0;
            end
            r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
            return 1'b1;
          end
          arfp_pkg::PH_HEX1: begin
            if (!hex_digit(b, nib)) begin
              r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
              return 1'b1;
            end
            sum_rx = {nib, 4'h0};
            ph     = arfp_pkg::PH_HEX2;
            return 1'b0;
          end
          arfp_pkg::PH_HEX2: begin
            if (!hex_digit(b, nib)) begin
              r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
              return 1'b1;
            end
            sum_rx[3:0] = nib;
            if (nak_path) r = end_frame(arfp_pkg::ST_NAK, code_acc, sum_rx == sum_acc);
            else r = end_frame(arfp_pkg::ST_ACK, '0, sum_rx == sum_acc);
            return 1'b1;
          end
          default: begin
            r = end_frame(arfp_pkg::ST_FORMAT, '0, 1'b0);
            return 1'b1;
          end
        endcase
      end
      arfp_pkg::OP_ARM: begin
        armed = 1'b1;
        clear_frame();
        return 1'b0;
      end
      arfp_pkg::OP_TIMEOUT: begin
        if (armed) begin
          r = end_frame(arfp_pkg::ST_TIMEOUT, '0, 1'b0);
          return 1'b1;
        end
        clear_frame();
        r = status_word(arfp_pkg::ST_IDLE_TO, '0, 1'b0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    arfp_pkg::result_t res;
    arfp_pkg::result_t want;
    if (!rst_n) begin
      armed = 1'b0;
      clear_frame();
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (decode_reply_step(in_op, in_rx_byte, res)) begin
          pending_results.insert(pending_results.size(), res);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          errs++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          check_field("kind", want.kind, out_kind);
          check_field("payload_byte", want.payload_byte, out_payload_byte);
          check_field("status", want.status, out_status);
          check_field("nak_code", want.nak_code, out_nak_code);
          check_field("checksum_ok", want.checksum_ok, out_checksum_ok);
          check_field("last", want.last, out_last);
        end
      end
    end
    mismatches  <= errs;
    outstanding <= pending_results.size();
  end

endmodule

>>> tb/ascii_reply_frame_parser_tb.sv
// Testbench top for the reply parser: clock, reset, reply stimulus and the final verdict.
module ascii_reply_frame_parser_tb;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [1:0]  in_op      = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_payload_byte;
  logic [2:0]  out_status;
  logic [9:0]  out_nak_code;
  logic        out_checksum_ok;
  logic        out_last;
  int unsigned mismatches;
  int unsigned outstanding;

  bit          calm   = 1'b0;
  int unsigned n_sent = 0;

  // Well-formed ACK reply, the leading '@' opening the frame; the checksum 0x59 matches
  logic [7:0] ack_frame[$] = {arfp_pkg::CH_AT, arfp_pkg::CH_AT, arfp_pkg::CH_AT,
                              arfp_pkg::CH_ZERO, arfp_pkg::CH_ZERO, arfp_pkg::CH_ZERO,
                              arfp_pkg::CH_UA, arfp_pkg::CH_UC, arfp_pkg::CH_UK,
                              8'hFF, 8'h00, arfp_pkg::CH_SEMI, 8'h35, 8'h39};

  ascii_reply_frame_parser u_dut (.*);

  ascii_reply_frame_parser_checker u_check (.*);

  always #2 clk = ~clk;

  always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 25);

  // Hold each transaction until accepted, with random gaps before it
  task automatic push_item(input logic [1:0] op, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_RESERVED) n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_reply(input bit damage);
    logic [7:0] frame[$];
    logic [7:0] c;
    logic [7:0] sum;
    logic [3:0] nib;
    logic [1:0] tail_op;
    bit         nak;
    bit         with_tail;
    int         n;
    int         cut;
    frame     = {};
    with_tail = 1'b0;
    tail_op   = arfp_pkg::OP_TIMEOUT;
    nak       = ($urandom_range(0, 2) == 0);
    push_item(arfp_pkg::OP_ARM, 8'($urandom_range(0, 255)));
    // Line noise before the first '@'
    repeat ($urandom_range(0, 3)) begin
      do c = 8'($urandom_range(0, 255)); while (c == arfp_pkg::CH_AT);
      push_item(arfp_pkg::OP_BYTE, c);
    end
    // Opening '@' followed by the "@@000" header
    frame = {arfp_pkg::CH_AT, arfp_pkg::CH_AT, arfp_pkg::CH_AT,
             arfp_pkg::CH_ZERO, arfp_pkg::CH_ZERO, arfp_pkg::CH_ZERO};
    if (nak) begin
      frame = {frame, arfp_pkg::CH_UN, arfp_pkg::CH_UA, arfp_pkg::CH_UK};
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
      repeat (n) frame = {frame, 8'(arfp_pkg::CH_ZERO + $urandom_range(0, 9))};
    end else begin
      frame = {frame, arfp_pkg::CH_UA, arfp_pkg::CH_UC, arfp_pkg::CH_UK};
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255)); while (c == arfp_pkg::CH_SEMI);
        frame = {frame, c};
      end
    end
    frame = {frame, arfp_pkg::CH_SEMI};
    sum = '0;
    foreach (frame[i]) sum = sum + frame[i];
    if ($urandom_range(0, 9) == 0) sum = sum + 8'($urandom_range(1, 255));
    for (int i = 1; i >= 0; i--) begin
      nib = i ? sum[7:4] : sum[3:0];
      if (nib < 10) c = arfp_pkg::CH_ZERO + nib;
      else c = ($urandom_range(0, 1) ? arfp_pkg::CH_UA : arfp_pkg::CH_LA) + nib - 8'd10;
      frame = {frame, c};
    end
    if (damage) begin
      cut = $urandom_range(0, frame.size() - 1);
      case ($urandom_range(0, 2))
        0: frame[cut] = 8'($urandom_range(0, 255));
        1: begin
          while (frame.size() > cut) frame.delete(frame.size() - 1);
          with_tail = 1'b1;
          tail_op   = arfp_pkg::OP_TIMEOUT;
        end
        default: begin
          while (frame.size() > cut) frame.delete(frame.size() - 1);
          with_tail = 1'b1;
          tail_op   = arfp_pkg::OP_ARM;
        end
      endcase
    end
    foreach (frame[i]) push_item(arfp_pkg::OP_BYTE, frame[i]);
    if (with_tail) push_item(tail_op, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  r;
    bit  paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_item(arfp_pkg::OP_BYTE, 8'hFF);
    push_item(arfp_pkg::OP_TIMEOUT, 8'h00);
    push_item(OP_RESERVED, 8'hA5);
    push_item(arfp_pkg::OP_ARM, 8'h00);
    push_item(arfp_pkg::OP_ARM, 8'hFF);
    push_item(arfp_pkg::OP_BYTE, 8'h00);
    foreach (ack_frame[i]) push_item(arfp_pkg::OP_BYTE, ack_frame[i]);
    push_item(arfp_pkg::OP_ARM, 8'h00);
    push_item(arfp_pkg::OP_TIMEOUT, 8'h00);
    push_item(arfp_pkg::OP_ARM, 8'h00);
    push_item(arfp_pkg::OP_BYTE, arfp_pkg::CH_AT);
    push_item(arfp_pkg::OP_BYTE, 8'h58);
    drain_results();

    while (n_sent < 1600) begin
      calm = (n_sent >= 600 && n_sent < 900);
      if (!paused && n_sent >= 1000) begin
        drain_results();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) send_reply(1'b0);
      else if (r < 88) send_reply(1'b1);
      else repeat ($urandom_range(1, 4)) begin
        push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("ascii_reply_frame_parser_tb passed");
    else $display("ascii_reply_frame_parser_tb failed");
    $finish;
  end

  initial begin
    #800000;
    $display("ascii_reply_frame_parser_tb failed");
    $finish;
  end

endmodule
